/* design/sqs_pkg.sv */
// Shared types, sizes and controller/datapath interface structs for the sequence sorter.
// No dependencies; imported by sqs_ctrl, sqs_dpath and sequence_sorter.
package sqs_pkg;

    localparam int MAX_ITEMS = 64;
    localparam int DATA_W    = 32;
    localparam int ADDR_W    = $clog2(MAX_ITEMS);
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
    localparam int SUM_W     = CNT_W + 1;

    typedef logic signed [DATA_W-1:0] data_t;
    typedef logic [CNT_W-1:0]         cnt_t;
    typedef logic [ADDR_W-1:0]        addr_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_PASS_CHK,
        ST_RUN_SETUP,
        ST_MERGE_RD,
        ST_MERGE_WR,
        ST_EMIT_RD,
        ST_EMIT_CAP,
        ST_EMIT_HOLD
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic sort_init;
        logic run_setup;
        logic pass_end;
        logic merge_step;
        logic emit_start;
        logic emit_sel;
        logic emit_capture;
        logic emit_next;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic sort_done;
        logic run_end;
        logic pair_last;
        logic emit_last;
    } status_t;

endpackage

/* design/sqs_ram.sv */
// Generic RAM: one write port, two read ports, registered read data.
// No dependencies.
module sqs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_a_reg <= mem_reg[raddr_a];
        rdata_b_reg <= mem_reg[raddr_b];
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

/* design/sqs_ctrl.sv */
// Sequencer for load, bottom-up merge passes and result emission.
// Depends on sqs_pkg.
module sqs_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    input  logic             s_tlast,
    output logic             s_tready,
    output logic             m_tvalid,
    input  logic             m_tready,
    input  sqs_pkg::status_t sts,
    output sqs_pkg::cmd_t    cmd
);
    import sqs_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        unique case (state_reg)
            ST_LOAD: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load = 1'b1;
                    if (s_tlast) begin
                        cmd.sort_init = 1'b1;
                        state_next    = ST_PASS_CHK;
                    end
                end
            end
            ST_PASS_CHK: begin
                if (sts.sort_done) begin
                    cmd.emit_start = 1'b1;
                    state_next     = ST_EMIT_RD;
                end else begin
                    state_next = ST_RUN_SETUP;
                end
            end
            ST_RUN_SETUP: begin
                if (sts.run_end) begin
                    cmd.pass_end = 1'b1;
                    state_next   = ST_PASS_CHK;
                end else begin
                    cmd.run_setup = 1'b1;
                    state_next    = ST_MERGE_RD;
                end
            end
            ST_MERGE_RD: begin
                state_next = ST_MERGE_WR;
            end
            ST_MERGE_WR: begin
                cmd.merge_step = 1'b1;
                state_next     = sts.pair_last ? ST_RUN_SETUP : ST_MERGE_RD;
            end
            ST_EMIT_RD: begin
                cmd.emit_sel = 1'b1;
                state_next   = ST_EMIT_CAP;
            end
            ST_EMIT_CAP: begin
                cmd.emit_sel     = 1'b1;
                cmd.emit_capture = 1'b1;
                state_next       = ST_EMIT_HOLD;
            end
            ST_EMIT_HOLD: begin
                m_tvalid = 1'b1;
                if (m_tready) begin
                    cmd.emit_next = 1'b1;
                    state_next    = sts.emit_last ? ST_LOAD : ST_EMIT_RD;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

endmodule

/* design/sqs_dpath.sv */
// Datapath: two ping-pong value banks, run pointers, merge compare, output register.
// Depends on sqs_pkg and sqs_ram.
module sqs_dpath (
    input  logic             aclk,
    input  logic             aresetn,
    input  sqs_pkg::data_t   s_tdata,
    input  sqs_pkg::cmd_t    cmd,
    output sqs_pkg::status_t sts,
    output sqs_pkg::data_t   out_data,
    output logic             out_last,
    output logic             out_drop
);
    import sqs_pkg::*;

    cnt_t  count_reg, count_next;
    logic  ovf_reg, ovf_next;
    cnt_t  w_reg, w_next;
    cnt_t  lo_reg, lo_next;
    cnt_t  mid_reg, mid_next;
    cnt_t  hi_reg, hi_next;
    cnt_t  i_reg, i_next;
    cnt_t  j_reg, j_next;
    cnt_t  k_reg, k_next;
    logic  src_reg, src_next;
    data_t out_data_reg;
    logic  out_last_reg;
    logic  out_drop_reg;

    logic [SUM_W-1:0] mid_sum;
    logic [SUM_W-1:0] hi_sum;
    logic [SUM_W-1:0] k_inc;
    cnt_t  mid_calc;
    cnt_t  hi_calc;
    logic  has_room;
    logic  take_a;

    logic  b0_we, b1_we;
    addr_t waddr, raddr_a, raddr_b;
    data_t wdata;
    data_t b0_rd_a, b0_rd_b, b1_rd_a, b1_rd_b;
    data_t rd_a, rd_b;

    sqs_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ITEMS)) u_bank0 (
        .aclk    (aclk),
        .we      (b0_we),
        .waddr   (waddr),
        .wdata   (wdata),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (b0_rd_a),
        .rdata_b (b0_rd_b)
    );

    sqs_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ITEMS)) u_bank1 (
        .aclk    (aclk),
        .we      (b1_we),
        .waddr   (waddr),
        .wdata   (wdata),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (b1_rd_a),
        .rdata_b (b1_rd_b)
    );

    assign rd_a = src_reg ? b1_rd_a : b0_rd_a;
    assign rd_b = src_reg ? b1_rd_b : b0_rd_b;

    // run bounds, clipped to the held count
    assign mid_sum  = {1'b0, lo_reg} + {1'b0, w_reg};
    assign hi_sum   = {1'b0, lo_reg} + ({1'b0, w_reg} << 1);
    assign mid_calc = (mid_sum > {1'b0, count_reg}) ? count_reg : mid_sum[CNT_W-1:0];
    assign hi_calc  = (hi_sum > {1'b0, count_reg}) ? count_reg : hi_sum[CNT_W-1:0];
    assign k_inc    = {1'b0, k_reg} + SUM_W'(1);

    assign has_room = (count_reg != CNT_W'(MAX_ITEMS));
    assign take_a   = (i_reg < mid_reg) && ((j_reg >= hi_reg) || (rd_a <= rd_b));

    assign waddr   = cmd.load ? count_reg[ADDR_W-1:0] : k_reg[ADDR_W-1:0];
    assign wdata   = cmd.load ? s_tdata : (take_a ? rd_a : rd_b);
    assign b0_we   = (cmd.load && has_room) || (cmd.merge_step && src_reg);
    assign b1_we   = cmd.merge_step && !src_reg;
    assign raddr_a = cmd.emit_sel ? k_reg[ADDR_W-1:0] : i_reg[ADDR_W-1:0];
    assign raddr_b = j_reg[ADDR_W-1:0];

    assign sts.sort_done = (w_reg >= count_reg);
    assign sts.run_end   = (lo_reg >= count_reg);
    assign sts.pair_last = (k_inc == {1'b0, hi_reg});
    assign sts.emit_last = (k_inc == {1'b0, count_reg});

    always_comb begin
        count_next = count_reg;
        ovf_next   = ovf_reg;
        w_next     = w_reg;
        lo_next    = lo_reg;
        mid_next   = mid_reg;
        hi_next    = hi_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        src_next   = src_reg;
        if (cmd.load) begin
            if (has_room) begin
                count_next = count_reg + CNT_W'(1);
            end else begin
                ovf_next = 1'b1;
            end
        end
        if (cmd.sort_init) begin
            w_next   = CNT_W'(1);
            lo_next  = '0;
            src_next = 1'b0;
        end
        if (cmd.run_setup) begin
            i_next   = lo_reg;
            mid_next = mid_calc;
            j_next   = mid_calc;
            hi_next  = hi_calc;
            k_next   = lo_reg;
        end
        if (cmd.merge_step) begin
            if (take_a) begin
                i_next = i_reg + CNT_W'(1);
            end else begin
                j_next = j_reg + CNT_W'(1);
            end
            k_next = k_inc[CNT_W-1:0];
            if (sts.pair_last) begin
                lo_next = hi_reg;
            end
        end
        if (cmd.pass_end) begin
            src_next = !src_reg;
            w_next   = w_reg << 1;
            lo_next  = '0;
        end
        if (cmd.emit_start) begin
            k_next = '0;
        end
        if (cmd.emit_next) begin
            k_next = k_inc[CNT_W-1:0];
            if (sts.emit_last) begin
                count_next = '0;
                ovf_next   = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end else begin
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end

    always_ff @(posedge aclk) begin
        w_reg   <= w_next;
        lo_reg  <= lo_next;
        mid_reg <= mid_next;
        hi_reg  <= hi_next;
        i_reg   <= i_next;
        j_reg   <= j_next;
        k_reg   <= k_next;
        src_reg <= src_next;
        if (cmd.emit_capture) begin
            out_data_reg <= rd_a;
            out_last_reg <= sts.emit_last;
            out_drop_reg <= ovf_reg;
        end
    end

    assign out_data = out_data_reg;
    assign out_last = out_last_reg;
    assign out_drop = out_drop_reg;

endmodule

/* design/sequence_sorter.sv */
// Top level of the sequence sorter: collects a set of signed values, merge-sorts, streams out.
// Depends on sqs_pkg, sqs_ctrl, sqs_dpath (and sqs_ram below it).
//
// Usage:
//   Slave channel: one signed 32-bit value per beat, s_tlast on the final value of a set.
//   Up to MAX_ITEMS (64) values are held; further values of the set are discarded and
//   every result of that set then shows m_tuser (dropped) high. A value carrying
//   s_tlast is also discarded when the store is full, the set is still sorted.
//   Master channel: the held values in ascending signed order, m_tlast on the largest.
// Timing:
//   Load: one beat per cycle, s_tready stays high until the set's final beat.
//   Sort: bottom-up merge across two 64-entry RAM banks, ping-pong per pass.
//     For n held values, ceil(log2 n) passes; in a pass each element takes a RAM read
//     state and a compare/write state, each run pair a run setup state, and each pass
//     a closing run setup and a pass check.
//   Emit: per result a RAM read, a capture and an output beat, held while m_tready is
//     low; the next result is read only once the current beat is taken.
//   s_tready is low from the final input beat until the final result beat is taken.
// Reset: aresetn (synchronous, active low) empties the store, clears the dropped
//   flag and returns to loading; any set in progress is lost.
// Stall: a low m_tready holds the current result beat; the block simply waits.
module sequence_sorter (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [31:0]           s_tdata,    // [31:0] value
    input  logic                  s_tlast,    // last
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [31:0]           m_tdata,    // [31:0] sorted_value
    output logic                  m_tlast,    // end_of_set
    output logic                  m_tuser     // [0] dropped
);
    import sqs_pkg::*;

    cmd_t    cmd;
    status_t sts;
    data_t   out_data;

    sqs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    sqs_dpath u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  ($signed(s_tdata)),
        .cmd      (cmd),
        .sts      (sts),
        .out_data (out_data),
        .out_last (m_tlast),
        .out_drop (m_tuser)
    );

    assign m_tdata = $unsigned(out_data);

endmodule

/* design/sqs_checker.sv */
// Port-level checks for the sequence sorter, bound to the top level.
// Depends on sequence_sorter (bind target); no package use.
module sqs_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tlast,
    input logic        m_tuser
);

    logic        in_set_reg;
    logic [31:0] prev_val_reg;
    logic        prev_drop_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_set_reg <= 1'b0;
        end else if (m_tvalid && m_tready) begin
            in_set_reg <= !m_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (m_tvalid && m_tready) begin
            prev_val_reg  <= m_tdata;
            prev_drop_reg <= m_tuser;
        end
    end

    // stalled result beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)
                                     && $stable(m_tuser)))
        else $error("result beat changed while stalled");

    // never ready for input while a result is offered
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input ready while a result is offered");

    // ascending order within a set
    a_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && in_set_reg) |-> ($signed(m_tdata) >= $signed(prev_val_reg)))
        else $error("results out of order");

    // dropped flag constant across a set
    a_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && in_set_reg) |-> (m_tuser == prev_drop_reg))
        else $error("dropped flag changed within a set");

    // output idle and input ready again after the final result
    a_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> (!m_tvalid && s_tready))
        else $error("block did not return to loading after the set");

endmodule

bind sequence_sorter sqs_checker u_sqs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
